>>> rtl/md5_stream_hash_core_macros.svh
// Assertion macros for the MD5 stream hash core checker.
// Included by the checker file only; depends on a clk_i/rst_ni pair in scope.
`ifndef MD5_STREAM_HASH_CORE_MACROS_SVH
`define MD5_STREAM_HASH_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MD5_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("md5 core assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MD5_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("md5 core assertion failed");

`endif

>>> rtl/md5_pkg.sv
// Shared types, constants and round helper functions for the MD5 core.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package md5_pkg;

  // Source of the byte written into the block buffer.
  typedef enum logic [1:0] {
    BSRC_DATA = 2'd0,
    BSRC_PAD  = 2'd1,
    BSRC_ZERO = 2'd2
  } byte_src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      wr_byte;
    byte_src_e byte_src;
    logic      cnt_add;
    logic      wr_len;
    logic      comp_start;
    logic      comp_round;
    logic      comp_fin;
    logic      dig_load;
  } md5_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pos_wrap;
    logic pos_len;
    logic round_last;
    logic out_busy;
  } md5_sts_t;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [5:0]  POS_LAST     = 6'd63;
  localparam logic [5:0]  PAD_END_POS  = 6'd56;
  localparam logic [5:0]  ROUND_LAST   = 6'd63;
  localparam logic [3:0]  LEN_LO_IDX   = 4'd14;
  localparam logic [3:0]  LEN_HI_IDX   = 4'd15;
  localparam logic [63:0] BIT_STEP     = 64'd8;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] r4;
    logic [3:0] idx;
    r4 = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    idx = r4;
      2'd1:    idx = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    idx = 4'(r4 * 4'd3 + 4'd5);
      default: idx = 4'(r4 * 4'd7);
    endcase
    return idx;
  endfunction

  // Left rotate amount for a given round.
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    unique case ({rnd[5:4], rnd[1:0]})
      4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
      4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
      4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
      4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/md5_ctrl.sv
// Sequencer for the MD5 core: byte intake, padding, compression and digest hand-off.
// Depends on md5_pkg for the command and status structs.
`default_nettype none

module md5_ctrl import md5_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     byte_present_i,
  input  wire logic     end_of_message_i,
  input  wire md5_sts_t sts_i,
  output md5_cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_COMP  = 3'd3;
  localparam logic [2:0] S_FEED  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;

  // Requests are taken only while waiting for input.
  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.wr_byte  = 1'b1;
            cmd_o.byte_src = BSRC_DATA;
            cmd_o.cnt_add  = 1'b1;
          end
          if (byte_present_i && sts_i.pos_wrap) begin
            cmd_o.comp_start = 1'b1;
            state_d          = S_COMP;
            ret_d            = end_of_message_i ? S_PAD80 : S_IDLE;
          end else if (end_of_message_i) begin
            state_d = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd_o.wr_byte  = 1'b1;
        cmd_o.byte_src = BSRC_PAD;
        if (sts_i.pos_wrap) begin
          cmd_o.comp_start = 1'b1;
          state_d          = S_COMP;
          ret_d            = S_PADZ;
        end else begin
          state_d = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts_i.pos_len) begin
          // Length words go in and the final block is compressed.
          cmd_o.wr_len     = 1'b1;
          cmd_o.comp_start = 1'b1;
          state_d          = S_COMP;
          ret_d            = S_DONE;
        end else begin
          cmd_o.wr_byte  = 1'b1;
          cmd_o.byte_src = BSRC_ZERO;
          if (sts_i.pos_wrap) begin
            cmd_o.comp_start = 1'b1;
            state_d          = S_COMP;
            ret_d            = S_PADZ;
          end
        end
      end
      S_COMP: begin
        cmd_o.comp_round = 1'b1;
        if (sts_i.round_last) begin
          state_d = S_FEED;
        end
      end
      S_FEED: begin
        cmd_o.comp_fin = 1'b1;
        state_d        = ret_q;
      end
      S_DONE: begin
        // Wait until the previous digest has been fully taken.
        if (!sts_i.out_busy) begin
          cmd_o.dig_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/md5_dp.sv
// Datapath for the MD5 core: block buffer, length counter, round unit,
// chaining state and the digest output register. Depends on md5_pkg.
`default_nettype none

module md5_dp import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire md5_cmd_t    cmd_i,
  output md5_sts_t         sts_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [1:0]       word_number_o,
  output logic             last_word_o
);

  logic [31:0] buf_q [16];
  logic [31:0] chain_q [4];
  logic [31:0] work_q [4];
  logic [31:0] dig_q [4];
  logic [5:0]  pos_q;
  logic [63:0] bitcnt_q;
  logic [5:0]  round_q;
  logic [1:0]  out_cnt_q;
  logic        out_busy_q;

  logic [7:0]  wbyte;
  logic [31:0] f_val;
  logic [31:0] t_val;
  logic [63:0] rot_dbl;
  logic [31:0] b_new;
  logic        out_take;

  // Byte to be written into the buffer.
  always_comb begin
    unique case (cmd_i.byte_src)
      BSRC_DATA: wbyte = data_byte_i;
      BSRC_PAD:  wbyte = PAD_BYTE;
      BSRC_ZERO: wbyte = '0;
      default:   wbyte = '0;
    endcase
  end

  // Round function, one round per cycle.
  always_comb begin
    unique case (round_q[5:4])
      2'd0:    f_val = (work_q[1] & work_q[2]) | (~work_q[1] & work_q[3]);
      2'd1:    f_val = (work_q[1] & work_q[3]) | (work_q[2] & ~work_q[3]);
      2'd2:    f_val = work_q[1] ^ work_q[2] ^ work_q[3];
      default: f_val = work_q[2] ^ (work_q[1] | ~work_q[3]);
    endcase
    t_val   = work_q[0] + f_val + ROUND_K[round_q] + buf_q[msg_index(round_q)];
    rot_dbl = {t_val, t_val} << rot_amount(round_q);
    b_new   = work_q[1] + rot_dbl[63:32];
  end

  // Status back to the controller.
  assign sts_o.pos_wrap   = (pos_q == POS_LAST);
  assign sts_o.pos_len    = (pos_q == PAD_END_POS);
  assign sts_o.round_last = (round_q == ROUND_LAST);
  assign sts_o.out_busy   = out_busy_q;

  // Block buffer: byte writes and length words.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_byte) begin
      buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wbyte;
    end
    if (cmd_i.wr_len) begin
      buf_q[LEN_LO_IDX] <= bitcnt_q[31:0];
      buf_q[LEN_HI_IDX] <= bitcnt_q[63:32];
    end
  end

  // Working variables.
  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      work_q <= chain_q;
    end else if (cmd_i.comp_round) begin
      work_q[0] <= work_q[3];
      work_q[1] <= b_new;
      work_q[2] <= work_q[1];
      work_q[3] <= work_q[2];
    end
  end

  // Digest holding register, loaded when a message finishes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.dig_load) begin
      dig_q <= chain_q;
    end
  end

  // Position, length, round and chaining state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      bitcnt_q <= '0;
      round_q  <= '0;
      chain_q  <= CHAIN_INIT;
    end else begin
      if (cmd_i.dig_load) begin
        pos_q    <= '0;
        bitcnt_q <= '0;
        chain_q  <= CHAIN_INIT;
      end else begin
        if (cmd_i.wr_byte) begin
          pos_q <= pos_q + 6'd1;
        end
        if (cmd_i.cnt_add) begin
          bitcnt_q <= bitcnt_q + BIT_STEP;
        end
        if (cmd_i.comp_fin) begin
          for (int i = 0; i < 4; i++) begin
            chain_q[i] <= chain_q[i] + work_q[i];
          end
        end
      end
      if (cmd_i.comp_start) begin
        round_q <= '0;
      end else if (cmd_i.comp_round) begin
        round_q <= round_q + 6'd1;
      end
    end
  end

  // Output stage: four digest words, A first.
  assign out_take = out_busy_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_busy_q <= 1'b0;
      out_cnt_q  <= '0;
    end else if (cmd_i.dig_load) begin
      out_busy_q <= 1'b1;
      out_cnt_q  <= '0;
    end else if (out_take) begin
      out_cnt_q <= out_cnt_q + 2'd1;
      if (out_cnt_q == 2'd3) begin
        out_busy_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_busy_q;
  assign digest_word_o = dig_q[out_cnt_q];
  assign word_number_o = out_cnt_q;
  assign last_word_o   = (out_cnt_q == 2'd3);

endmodule

`default_nettype wire

>>> rtl/md5_stream_hash_core.sv
// MD5 stream hash core: byte input channel, digest word output channel.
// The block accepts one request per message byte on the input channel
// (data_byte_i, byte_present_i, end_of_message_i) with valid/ready.
// Bytes are packed little-endian into a 16-word buffer; a byte that
// completes a 64-byte block starts a compression (the byte write, 64
// rounds of the single round unit, then the feed-forward add), and no
// further request is taken until that compression has finished.
// An end-of-message request pads one byte per cycle, pausing for any
// block compression, up to byte 56, writes the length, and compresses
// one or two blocks before the digest is loaded for output.
// The digest leaves as four requests A, B, C, D (word_number 0..3,
// last_word on D) from a holding register, so the next message is
// accepted while the receiver still drains the previous digest; a
// second finish waits only if the old digest is not yet fully taken.
// A stalled receiver holds the current word steady.
// Reset restores the standard chaining values and an empty message.
// Depends on md5_pkg, md5_ctrl and md5_dp.
`default_nettype none

module md5_stream_hash_core import md5_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_present_i,
  input  wire logic        end_of_message_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [1:0]       word_number_o,
  output logic             last_word_o
);

  md5_cmd_t cmd;
  md5_sts_t sts;

  // Sequencer.
  md5_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .sts_i            (sts),
    .cmd_o            (cmd)
  );

  // Buffer, round unit and output stage.
  md5_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_number_o (word_number_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

>>> rtl/md5_checker.sv
// Port-level checker for the MD5 stream hash core, bound to the top level.
// Depends on md5_stream_hash_core_macros.svh for the assertion macros.
`default_nettype none

`include "md5_stream_hash_core_macros.svh"

module md5_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        end_of_message_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [1:0]  word_number_o,
  input wire logic        last_word_o
);

  // The last-word flag marks word D and nothing else.
  `MD5_ASSERT_NOW(a_last_is_d, out_valid_o, last_word_o == (word_number_o == 2'd3))

  // Digest words follow each other in order without gaps in numbering.
  `MD5_ASSERT_NEXT(a_word_order, out_valid_o && out_ready_i && !last_word_o, out_valid_o && (word_number_o == $past(word_number_o) + 2'd1))

  // A stalled digest word holds.
  `MD5_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(digest_word_o))

  // Finishing a message always takes the block away from byte intake.
  `MD5_ASSERT_NEXT(a_eom_busy, in_valid_i && in_ready_o && end_of_message_i, !in_ready_o)

endmodule

bind md5_stream_hash_core md5_checker u_md5_checker (.*);

`default_nettype wire
